// ----- rtl/core/itp_pkg.sv -----
// Shared constants, types and the precedence function of the infix-to-postfix converter.
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_TERM  = 8'h00;

  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;
  localparam logic [1:0] PREC_POW  = 2'd3;

  // Stack command from the sequencer to the stack unit.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic       rd_en;
    logic [7:0] wdata;
  } stk_ctrl_t;

  function automatic logic [1:0] prec_of(input logic [7:0] ch);
    logic [1:0] p;
    unique case (ch)
      CH_PLUS, CH_MINUS:        p = PREC_ADD;
      CH_MUL, CH_DIV, CH_MOD:   p = PREC_MUL;
      CH_POW:                   p = PREC_POW;
      default:                  p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/itp_stack.sv -----
// Operator stack: memory with a registered read port at the top entry and the entry count.
module itp_stack import itp_pkg::*; #(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned TW   = $clog2(DEPTH + 1),
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stk_ctrl_t     ctrl_i,
  output logic [TW-1:0] top_o,
  output logic          empty_o,
  output logic          full_o,
  output logic [7:0]    rd_data_o
);

  logic [7:0]    mem [DEPTH];
  logic [TW-1:0] top_q, top_d;
  logic [TW-1:0] top_m1;
  logic [7:0]    rd_q;

  assign top_m1    = top_q - TW'(1);
  assign empty_o   = (top_q == '0);
  assign full_o    = (top_q == TW'(DEPTH));
  assign top_o     = top_q;
  assign rd_data_o = rd_q;

  always_comb begin
    top_d = top_q;
    if (ctrl_i.clear) begin
      top_d = '0;
    end else if (ctrl_i.push && !full_o) begin
      top_d = top_q + TW'(1);
    end else if (ctrl_i.pop && !empty_o) begin
      top_d = top_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !full_o) begin
      mem[top_q[AW-1:0]] <= ctrl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en && !empty_o) begin
      rd_q <= mem[top_m1[AW-1:0]];
    end
  end

endmodule

// ----- rtl/core/infix_to_postfix_converter.sv -----
// Top level of the shunting-yard infix-to-postfix converter: sequencer and output register.
//
// Channel   Dir  tdata           tlast          tuser
// s_axis    in   symbol[7:0]     end_of_expr    -
// m_axis    out  out_symbol[7:0] last_of_expr   stack_fault
//
// An operand goes to S_EMIT and '(' is pushed in S_IDLE; an operator or ')' passes S_READ
// and S_CHECK for every look at the stack top, because each look at the stack top goes
// through the registered read port of the stack memory.
// The end-of-expression flush pops every stacked entry, looks once more at the empty
// stack and then sends the terminator from S_TERM.
// After reset the stack is empty and the fault flag is clear; no clearing pass is needed.
// A stalled output holds its word; the sequencer waits when it has a word to load, but S_IDLE still accepts input.
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned TW         = $clog2(STACK_DEPTH + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_symbol
  output logic       m_axis_tlast_o,
  output logic       m_axis_tuser_o    // [0] stack_fault
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_EMIT  = 5'b01000,
    S_TERM  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    sym_q, sym_d;
  logic          last_q, last_d;
  logic          flush_q, flush_d;
  logic          fault_q, fault_d;
  stk_ctrl_t     ctrl;
  logic [TW-1:0] stk_top;
  logic          stk_empty, stk_full;
  logic [7:0]    stk_rd;

  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic          out_last_q, out_fault_q;
  logic          out_free;
  logic          ld;
  logic [7:0]    ld_data;
  logic          ld_last;

  itp_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .top_o     (stk_top),
    .empty_o   (stk_empty),
    .full_o    (stk_full),
    .rd_data_o (stk_rd)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_fault_q;

  always_comb begin
    state_d = state_q;
    sym_d   = sym_q;
    last_d  = last_q;
    flush_d = flush_q;
    fault_d = fault_q;
    ctrl    = '0;
    ld      = 1'b0;
    ld_data = CH_TERM;
    ld_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          sym_d   = s_axis_tdata_i;
          last_d  = s_axis_tlast_i;
          flush_d = 1'b0;
          if ((prec_of(s_axis_tdata_i) != PREC_NONE) || (s_axis_tdata_i == CH_RPAR)) begin
            state_d = S_READ;
          end else if (s_axis_tdata_i == CH_LPAR) begin
            if (stk_full) begin
              fault_d = 1'b1;
            end else begin
              ctrl.push  = 1'b1;
              ctrl.wdata = s_axis_tdata_i;
            end
            if (s_axis_tlast_i) begin
              flush_d = 1'b1;
              state_d = S_READ;
            end
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_READ: begin
        ctrl.rd_en = !stk_empty;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        // Either pop the top into the output or finish the character; during the flush, finish by going to S_TERM.
        if (flush_q) begin
          if (!stk_empty) begin
            if (out_free) begin
              ld       = 1'b1;
              ld_data  = stk_rd;
              ctrl.pop = 1'b1;
              state_d  = S_READ;
            end
          end else begin
            state_d = S_TERM;
          end
        end else if ((sym_q == CH_RPAR) ? (!stk_empty && stk_rd != CH_LPAR)
                     : (!stk_empty && prec_of(stk_rd) >= prec_of(sym_q))) begin
          if (out_free) begin
            ld       = 1'b1;
            ld_data  = stk_rd;
            ctrl.pop = 1'b1;
            state_d  = S_READ;
          end
        end else begin
          if (sym_q == CH_RPAR) begin
            if (!stk_empty) begin
              ctrl.pop = 1'b1;
            end else begin
              fault_d = 1'b1;
            end
          end else if (stk_full) begin
            fault_d = 1'b1;
          end else begin
            ctrl.push  = 1'b1;
            ctrl.wdata = sym_q;
          end
          if (last_q) begin
            flush_d = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_data = sym_q;
          if (last_q) begin
            flush_d = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_data    = CH_TERM;
          ld_last    = 1'b1;
          fault_d    = 1'b0;
          ctrl.clear = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flush_q     <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
      fault_q <= fault_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    last_q <= last_d;
    if (ld) begin
      out_data_q  <= ld_data;
      out_last_q  <= ld_last;
      out_fault_q <= fault_q;
    end
  end

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o == CH_TERM))
    else $error("terminator word carries a nonzero symbol");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_top <= TW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TERM && out_free) |=> (!fault_q && stk_top == '0))
    else $error("fault flag or stack not cleared after terminator");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i != CH_LPAR) |=> !s_axis_tready_o)
    else $error("input taken again while a character is in work");

  a_no_load_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !ld)
    else $error("output word overwritten while stalled");

endmodule
